/* src/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and controller/datapath interface types for the
// trial-division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Width of the number under test (low bits of the candidate field)
    localparam int VALUE_W = 32;
    // Width of the candidate and tested_value fields
    localparam int FIELD_W = 32;
    // Bit counter for the restoring divider
    localparam int CNT_W   = $clog2(VALUE_W);
    // Output beat width, bytes rounded up
    localparam int OUT_W   = ((FIELD_W + 1 + 7) / 8) * 8;

    // First trial divisor
    localparam logic [VALUE_W-1:0] FIRST_DIVISOR = VALUE_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_CHECK,
        ST_PRIME,
        ST_COMPOSITE
    } tdpt_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture candidate, divisor back to two
        logic start;     // initialise divider for current divisor
        logic step;      // one quotient bit
        logic next_d;    // advance to next divisor
        logic finish;    // write result register
        logic prime;     // verdict written on finish
    } tdpt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic below_two; // candidate below two
        logic div_last;  // final quotient bit this cycle
        logic quo_lt_d;  // quotient below divisor: no divisor left to try
        logic rem_zero;  // divisor divides the candidate
        logic out_free;  // result register may take a new result
    } tdpt_status_t;

endpackage

/* src/trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// Flow: a candidate below two goes from ST_IDLE through ST_START and ST_COMPOSITE
// to the result register; otherwise each trial divisor runs a full pass of the
// bit-serial divider, with up to floor(sqrt(n)) trials.
// Throughput: one candidate at a time; the next beat is taken in the cycle after
// the result enters the output register, which waits while m_tready is low.
// Reset: asynchronous, active low; clears the sequencer and result valid.
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Tests each candidate for primality by trial division and returns the
// candidate with a prime flag.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tdpt_pkg::FIELD_W-1:0]  s_tdata,   // [31:0] candidate
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tdpt_pkg::OUT_W-1:0]    m_tdata    // [31:0] tested_value,
                                                     // [32] is_prime, rest zero
);
    import tdpt_pkg::*;

    tdpt_cmd_t          cmd;
    tdpt_status_t       status;
    logic [FIELD_W-1:0] tested_value;
    logic               is_prime;

    tdpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdpt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .candidate    (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .tested_value (tested_value),
        .is_prime     (is_prime)
    );

    // Pack the result beat
    assign m_tdata = OUT_W'({is_prime, tested_value});

endmodule

/* src/tdpt_datapath.sv */
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate and divisor registers, bit-serial restoring divider and the
// result register facing the output stream.
// ----------------------------------------------------------------------------
module tdpt_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tdpt_pkg::FIELD_W-1:0]    candidate,
    input  tdpt_pkg::tdpt_cmd_t             cmd,
    output tdpt_pkg::tdpt_status_t          status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [tdpt_pkg::FIELD_W-1:0]    tested_value,
    output logic                            is_prime
);
    import tdpt_pkg::*;

    logic [VALUE_W-1:0] n_reg,   n_next;
    logic [VALUE_W-1:0] d_reg,   d_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] tested_reg, tested_next;
    logic               prime_reg, prime_next;

    logic [VALUE_W:0]   trial;
    logic [VALUE_W:0]   diff;
    logic               ge;

    // Restoring divide step: bring down the next dividend bit
    always_comb
    begin
        trial = {rem_reg, quo_reg[VALUE_W-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = (trial >= {1'b0, d_reg});
    end

    // Operand and divider registers
    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            n_next = VALUE_W'(candidate);
            d_next = FIRST_DIVISOR;
        end
        if (cmd.next_d)
        begin
            d_next = d_reg + VALUE_W'(1);
        end
        if (cmd.start)
        begin
            rem_next = '0;
            quo_next = n_reg;
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            rem_next = ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
            quo_next = {quo_reg[VALUE_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Result register: holds until the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        tested_next    = tested_reg;
        prime_next     = prime_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            tested_next    = FIELD_W'(n_reg);
            prime_next     = cmd.prime;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        tested_reg <= tested_next;
        prime_reg  <= prime_next;
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Status to controller
    always_comb
    begin
        status.below_two = (n_reg[VALUE_W-1:1] == '0);
        status.div_last  = (cnt_reg == CNT_W'(VALUE_W - 1));
        status.quo_lt_d  = (quo_reg < d_reg);
        status.rem_zero  = (rem_reg == '0);
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign tested_value = tested_reg;
    assign is_prime     = prime_reg;

endmodule

/* src/tdpt_ctrl.sv */
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for the trial loop: one division per divisor, stop at the first
// exact divisor or once the quotient falls below the divisor.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tdpt_pkg::tdpt_status_t  status,
    output tdpt_pkg::tdpt_cmd_t     cmd
);
    import tdpt_pkg::*;

    tdpt_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = status.below_two ? ST_COMPOSITE : ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (status.quo_lt_d)
                begin
                    state_next = ST_PRIME;
                end
                else if (status.rem_zero)
                begin
                    state_next = ST_COMPOSITE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_PRIME, ST_COMPOSITE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_START:
            begin
                cmd.start = !status.below_two;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_CHECK:
            begin
                // another divisor to try: move on and restart the divider
                if (!status.quo_lt_d && !status.rem_zero)
                begin
                    cmd.next_d = 1'b1;
                    cmd.start  = 1'b1;
                end
            end
            ST_PRIME:
            begin
                cmd.finish = status.out_free;
                cmd.prime  = 1'b1;
            end
            ST_COMPOSITE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* verif/tdpt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_checker
// Watches both stream channels of the prime tester. Every input beat is run
// through an independent trial-division predictor, and the verdict is queued.
// Every output beat is compared field by field against the oldest queued
// verdict. Mismatches and unexpected beats are counted for the top level.
// ----------------------------------------------------------------------------
module tdpt_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [tdpt_pkg::FIELD_W-1:0]  s_tdata,   // [31:0] candidate
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tdpt_pkg::OUT_W-1:0]    m_tdata,   // [31:0] tested_value,
                                                     // [32] is_prime, rest zero
    output int                            fail_count,
    output int                            pending_count
);

    import tdpt_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] tested_value;
        logic               is_prime;
    } verdict_t;

    verdict_t verdict_q[$];

    // Divisors only need to run up to the square root: any divisor up to
    // n/2 has a cofactor of at least two, and one of the pair is <= sqrt(n)
    function automatic logic trial_division_verdict(input longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t predict_verdict(input logic [FIELD_W-1:0] cand);
        longint unsigned n;
        verdict_t        v;
        // only the low VALUE_W bits take part
        n = 64'(cand) & ~({64{1'b1}} << VALUE_W);
        v.tested_value = n[FIELD_W-1:0];
        v.is_prime     = trial_division_verdict(n);
        return v;
    endfunction

    // Output beats are checked before the same edge's input is queued
    always @(posedge clk)
    begin
        int       errs;
        verdict_t want;
        errs = 0;
        if (!rst_n)
        begin
            verdict_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected result beat: tdata %h", m_tdata);
                    errs++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[FIELD_W-1:0] !== want.tested_value)
                    begin
                        $error("tested_value: expected %0d, got %0d",
                               want.tested_value, m_tdata[FIELD_W-1:0]);
                        errs++;
                    end
                    if (m_tdata[FIELD_W] !== want.is_prime)
                    begin
                        $error("is_prime: expected %0b, got %0b (value %0d)",
                               want.is_prime, m_tdata[FIELD_W], want.tested_value);
                        errs++;
                    end
                    if (m_tdata[OUT_W-1:FIELD_W+1] !== '0)
                    begin
                        $error("padding: expected 0, got %h",
                               m_tdata[OUT_W-1:FIELD_W+1]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                verdict_q.push_back(predict_verdict(s_tdata));
            fail_count    <= fail_count + errs;
            pending_count <= verdict_q.size();
        end
    end

endmodule

/* verif/tb_trial_division_prime_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test
// Stimulus and verdict for the trial-division prime tester. A directed set of
// edge values comes first, then random candidates weighted towards small
// numbers and large composites with a small factor, so that run time stays
// bounded. The sender runs in bursts, the receiver stalls in changing
// patterns and holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_test;

    import tdpt_pkg::*;

    localparam int RANDOM_ITEMS = 1930;
    localparam int IDLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [FIELD_W-1:0] EDGE_VALUES [20] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd25, 32'd49,
        32'd97, 32'd121,
        32'd65521,          // largest 16-bit prime
        32'd1042441,        // square of a prime, found only on the last trial
        32'd1048573,        // prime just below 2^20
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [FIELD_W-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;

    int                   fail_count;
    int                   pending_count;
    int                   sent_count;
    int                   idle_cycles;

    always #4 clk = ~clk;

    trial_division_prime_test dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tdpt_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Mostly cheap candidates; large ones are forced to carry a small factor
    function automatic logic [FIELD_W-1:0] pick_candidate();
        int unsigned        sel;
        int unsigned        f;
        logic [FIELD_W-1:0] r;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return FIELD_W'($urandom_range(0, 255));
        if (sel < 60)
            return FIELD_W'($urandom_range(0, 4095));
        if (sel < 63)
            return FIELD_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0:       f = 2;
            1:       f = 3;
            2:       f = 5;
            3:       f = 7;
            4:       f = 11;
            default: f = 13;
        endcase
        r = $urandom;
        if (r < f)
            r = f;
        return r - (r % f);
    endfunction

    // Sender: bursts of beats with idle gaps between them
    int burst_left;

    task automatic send_candidate(input logic [FIELD_W-1:0] cand);
        if (burst_left == 0)
        begin
            // lower valid only when a real gap follows
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cand;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        burst_left--;
    endtask

    // Main sequence: reset, directed, random, drain, verdict
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        sent_count = 0;
        burst_left = 4;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (EDGE_VALUES[i])
            send_candidate(EDGE_VALUES[i]);
        repeat (RANDOM_ITEMS)
            send_candidate(pick_candidate());

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("tb_trial_division_prime_test: done, clean");
        else
            $display("tb_trial_division_prime_test: done, errors");
        $finish;
    end

    // Receiver: changing stall patterns, one long hold-off to fill the block
    initial
    begin
        int unsigned mode;
        int unsigned span;
        bit          held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && sent_count >= 60)
                begin
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 9) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_trial_division_prime_test: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
